// ===== hdl/bmc_pkg.sv =====
// Shared constants, types and helpers of the maze carver.
package bmc_pkg;

  localparam int unsigned MaxSide  = 64;
  localparam int unsigned CoordW   = $clog2(MaxSide);
  localparam int unsigned CellIdW  = 2 * CoordW;
  localparam int unsigned Cells    = MaxSide * MaxSide;
  localparam int unsigned DistW    = 12;
  localparam int unsigned CountW   = CellIdW + 1;
  localparam int unsigned DimW     = 7;
  localparam int unsigned RandW    = 8;
  localparam int unsigned KindW    = 3;
  localparam int unsigned SideW    = 2;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic [KindW-1:0] {
    KIND_START     = 3'd0,
    KIND_CARVED    = 3'd1,
    KIND_BACKTRACK = 3'd2,
    KIND_FINISHED  = 3'd3,
    KIND_IDLE      = 3'd4
  } kind_e;

  typedef enum logic [SideW-1:0] {
    SIDE_BOTTOM = 2'd0,
    SIDE_LEFT   = 2'd1,
    SIDE_NONE   = 2'd2
  } side_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_START   = 1'b1;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Neighbour choice handed from the pick unit to the sequencer.
  typedef struct packed {
    logic any;
    dir_e dir;
  } pick_t;

  // Clamp a programmed dimension to the legal range.
  function automatic logic [DimW-1:0] eff_side(input logic [DimW-1:0] v);
    logic [DimW-1:0] res;
    if (v < DimW'(2)) res = DimW'(2);
    else if (v > DimW'(MaxSide)) res = DimW'(MaxSide);
    else res = v;
    return res;
  endfunction

endpackage

// ===== hdl/bmc_if.sv =====
// Handshake channel interfaces of the maze carver.
interface bmc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [bmc_pkg::RandW-1:0]    rand_value;
  modport source (output valid, opcode, rand_value, input ready);
  modport sink   (input valid, opcode, rand_value, output ready);
endinterface

interface bmc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bmc_pkg::KindW-1:0]     kind;
  logic [bmc_pkg::CoordW-1:0]    cell_row;
  logic [bmc_pkg::CoordW-1:0]    cell_col;
  logic [bmc_pkg::CoordW-1:0]    wall_row;
  logic [bmc_pkg::CoordW-1:0]    wall_col;
  logic [bmc_pkg::SideW-1:0]     wall_side;
  logic [bmc_pkg::DistW-1:0]     depth;
  modport source (output valid, kind, cell_row, cell_col, wall_row, wall_col, wall_side,
                  depth, input ready);
  modport sink   (input valid, kind, cell_row, cell_col, wall_row, wall_col, wall_side,
                  depth, output ready);
endinterface

interface bmc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic                        index;
  logic [bmc_pkg::DimW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bmc_pick.sv =====
// Picks one unvisited neighbour from the candidate mask and the random draw.
module bmc_pick (
  input  logic [3:0]                  cand_i,
  input  logic [bmc_pkg::RandW-1:0]   rand_i,
  output bmc_pkg::pick_t              pick_o
);

  logic [2:0] n;
  logic [3:0] fold1;
  logic [2:0] fold2;
  logic [1:0] mod3;
  logic [1:0] idx;
  logic [2:0] seen;
  logic [1:0] dir;

  always_comb begin
    // 4 is 1 mod 3, so fold base-4 digits twice
    fold1 = 4'(rand_i[1:0]) + 4'(rand_i[3:2]) + 4'(rand_i[5:4]) + 4'(rand_i[7:6]);
    fold2 = 3'(fold1[1:0]) + 3'(fold1[3:2]);
    if (fold2 >= 3'd6) mod3 = 2'(fold2 - 3'd6);
    else if (fold2 >= 3'd3) mod3 = 2'(fold2 - 3'd3);
    else mod3 = fold2[1:0];

    n = 3'($countones(cand_i));
    case (n)
      3'd2:    idx = {1'b0, rand_i[0]};
      3'd3:    idx = mod3;
      3'd4:    idx = rand_i[1:0];
      default: idx = 2'd0;
    endcase

    seen = 3'd0;
    dir  = 2'd0;
    for (int b = 0; b < 4; b++) begin
      if (cand_i[b]) begin
        if (seen == {1'b0, idx}) dir = 2'(b);
        seen = seen + 3'd1;
      end
    end

    pick_o.any = (n != 3'd0);
    pick_o.dir = bmc_pkg::dir_e'(dir);
  end

endmodule

// ===== hdl/backtracker_maze_carver_top.sv =====
// Maze carver top level: step sequencer, cell and stack memories, result register.
// Start item: a sweep of the whole cell memory (one entry a cycle).
// Advance item: five reads through the single cell-memory read port, then a carve or a backtrack
// that pops the stack; when the stack empties, the maze is finished by a scan of the border cells.
// One item in flight; a finished result waits in the output register.
// Reset clears control state only; the memories are swept by each start item.
module backtracker_maze_carver_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  bmc_in_if.sink           in_i,
  bmc_out_if.source        out_o,
  bmc_cfg_if.sink          cfg_i
);

  localparam int unsigned CW = bmc_pkg::CoordW;
  localparam int unsigned IW = bmc_pkg::CellIdW;
  localparam int unsigned DW = bmc_pkg::DistW;
  localparam int unsigned NW = bmc_pkg::CountW;
  localparam int unsigned MW = bmc_pkg::DimW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_NB     = 4'd2;
  localparam logic [3:0] S_PICK   = 4'd3;
  localparam logic [3:0] S_POP1   = 4'd4;
  localparam logic [3:0] S_POP2   = 4'd5;
  localparam logic [3:0] S_POP3   = 4'd6;
  localparam logic [3:0] S_EXIT   = 4'd7;
  localparam logic [3:0] S_EXLAST = 4'd8;
  localparam logic [3:0] S_EXRES  = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  // Configuration registers
  logic [MW-1:0] width_q, height_q;
  logic [MW-1:0] w_eff, h_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MW'(16);
      height_q <= MW'(16);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == bmc_pkg::REG_WIDTH) width_q <= cfg_i.data;
      else height_q <= cfg_i.data;
    end
  end

  assign w_eff = bmc_pkg::eff_side(width_q);
  assign h_eff = bmc_pkg::eff_side(height_q);

  // Control state
  logic [3:0]    state_q;
  logic          running_q;
  logic [NW-1:0] count_q;
  logic [CW-1:0] cur_r_q, cur_c_q;
  logic [bmc_pkg::RandW-1:0] rand_q;
  logic [2:0]    k_q;
  logic [3:0]    cand_q;
  logic [DW-1:0] cur_dist_q;
  logic [IW-1:0] sweep_q;

  // Exit scan
  logic          sc_first_q, sc_ph_q, sc_k_q;
  logic [CW-1:0] sc_i_q;
  logic          tag_v_q;
  logic [CW-1:0] tag_r_q, tag_c_q;
  logic [DW-1:0] best_q;
  logic [CW-1:0] best_r_q, best_c_q;

  // Pending result
  bmc_pkg::kind_e res_kind_q;
  logic [CW-1:0]  res_cr_q, res_cc_q, res_wr_q, res_wc_q;
  bmc_pkg::side_e res_side_q;
  logic [DW-1:0]  res_dep_q;

  // Output register; load it when the pending result can move in
  logic           out_valid_q;
  logic           emit_fire;

  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // Cell memory: {visited, distance}
  logic [DW:0]   cell_mem [bmc_pkg::Cells];
  logic [IW-1:0] cm_raddr, cm_waddr;
  logic [DW:0]   cm_wdata, cm_rdata_q;
  logic          cm_we;

  // Stack memory
  logic [IW-1:0] stk_mem [bmc_pkg::Cells];
  logic [IW-1:0] sk_raddr, sk_waddr, sk_wdata, sk_rdata_q;
  logic          sk_we;

  always_ff @(posedge clk_i) begin
    if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
    cm_rdata_q <= cell_mem[cm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sk_we) stk_mem[sk_waddr] <= sk_wdata;
    sk_rdata_q <= stk_mem[sk_raddr];
  end

  // Neighbour coordinates and grid membership, order up, left, down, right
  logic [CW-1:0] nb_r [4];
  logic [CW-1:0] nb_c [4];
  logic [3:0]    nb_in;

  always_comb begin
    nb_r[0] = cur_r_q - CW'(1);  nb_c[0] = cur_c_q;
    nb_r[1] = cur_r_q;           nb_c[1] = cur_c_q - CW'(1);
    nb_r[2] = cur_r_q + CW'(1);  nb_c[2] = cur_c_q;
    nb_r[3] = cur_r_q;           nb_c[3] = cur_c_q + CW'(1);
    nb_in[0] = (cur_r_q != '0) && (MW'(cur_r_q) - MW'(1) < h_eff) && (MW'(cur_c_q) < w_eff);
    nb_in[1] = (cur_c_q != '0) && (MW'(cur_r_q) < h_eff) && (MW'(cur_c_q) - MW'(1) < w_eff);
    nb_in[2] = (MW'(cur_r_q) + MW'(1) < h_eff) && (MW'(cur_c_q) < w_eff);
    nb_in[3] = (MW'(cur_r_q) < h_eff) && (MW'(cur_c_q) + MW'(1) < w_eff);
  end

  bmc_pkg::pick_t pick;

  bmc_pick u_pick (
    .cand_i (cand_q),
    .rand_i (rand_q),
    .pick_o (pick)
  );

  // Carve decode
  logic [CW-1:0] new_r, new_c, cw_r, cw_c;
  bmc_pkg::side_e cw_side;
  logic [DW-1:0] new_dist;
  logic [NW-1:0] count_dec;

  always_comb begin
    new_r = nb_r[pick.dir];
    new_c = nb_c[pick.dir];
    case (pick.dir)
      bmc_pkg::DIR_UP: begin
        cw_side = bmc_pkg::SIDE_BOTTOM; cw_r = cur_r_q; cw_c = cur_c_q;
      end
      bmc_pkg::DIR_DOWN: begin
        cw_side = bmc_pkg::SIDE_BOTTOM; cw_r = new_r; cw_c = cur_c_q;
      end
      bmc_pkg::DIR_LEFT: begin
        cw_side = bmc_pkg::SIDE_LEFT; cw_r = cur_r_q; cw_c = cur_c_q;
      end
      default: begin
        cw_side = bmc_pkg::SIDE_LEFT; cw_r = cur_r_q; cw_c = new_c;
      end
    endcase
    new_dist  = (cur_dist_q == bmc_pkg::DistMax) ? cur_dist_q : cur_dist_q + DW'(1);
    count_dec = (count_q != '0) ? count_q - NW'(1) : count_q;
  end

  // Exit scan address generation
  logic [CW-1:0] sc_r, sc_c;
  logic          sc_last;
  logic [CW-1:0] sc_lim;

  always_comb begin
    sc_r = '0;
    sc_c = '0;
    if (!sc_first_q) begin
      if (!sc_ph_q) begin
        sc_c = sc_i_q;
        sc_r = sc_k_q ? '0 : CW'(h_eff - MW'(1));
      end else begin
        sc_r = sc_i_q;
        sc_c = sc_k_q ? '0 : CW'(w_eff - MW'(1));
      end
    end
    sc_lim  = sc_ph_q ? CW'(h_eff - MW'(1)) : CW'(w_eff - MW'(1));
    sc_last = !sc_first_q && sc_ph_q && sc_k_q && (sc_i_q == sc_lim);
  end

  // Memory port steering
  always_comb begin
    cm_raddr = '0;
    cm_we    = 1'b0;
    cm_waddr = sweep_q;
    cm_wdata = {(sweep_q == '0), {DW{1'b0}}};
    sk_raddr = count_q[IW-1:0] - IW'(1);
    sk_we    = 1'b0;
    sk_waddr = '0;
    sk_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        cm_we = 1'b1;
        if (sweep_q == {IW{1'b1}}) sk_we = 1'b1;
      end
      S_NB: begin
        if (k_q == 3'd4) cm_raddr = {cur_r_q, cur_c_q};
        else cm_raddr = {nb_r[k_q[1:0]], nb_c[k_q[1:0]]};
      end
      S_PICK: begin
        if (pick.any) begin
          cm_we    = 1'b1;
          cm_waddr = {new_r, new_c};
          cm_wdata = {1'b1, new_dist};
          sk_we    = (count_q < NW'(bmc_pkg::Cells));
          sk_waddr = count_q[IW-1:0];
          sk_wdata = {new_r, new_c};
        end
      end
      S_POP2: cm_raddr = sk_rdata_q;
      S_EXIT: cm_raddr = {sc_r, sc_c};
      default: ;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      running_q  <= 1'b0;
      count_q    <= '0;
      cur_r_q    <= '0;
      cur_c_q    <= '0;
      k_q        <= '0;
      sweep_q    <= '0;
      sc_first_q <= 1'b1;
      sc_ph_q    <= 1'b0;
      sc_k_q     <= 1'b0;
      sc_i_q     <= '0;
      tag_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_fire) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            rand_q   <= in_i.rand_value;
            if (in_i.opcode == bmc_pkg::OP_START) begin
              sweep_q <= '0;
              state_q <= S_CLEAR;
            end else if (!running_q) begin
              res_kind_q <= bmc_pkg::KIND_IDLE;
              res_cr_q <= '0; res_cc_q <= '0; res_wr_q <= '0; res_wc_q <= '0;
              res_side_q <= bmc_pkg::SIDE_NONE;
              res_dep_q  <= '0;
              state_q    <= S_EMIT;
            end else begin
              k_q     <= '0;
              state_q <= S_NB;
            end
          end
        end
        S_CLEAR: begin
          // Sweep the whole cell memory; entry 0 comes out visited at distance 0
          sweep_q <= sweep_q + IW'(1);
          if (sweep_q == {IW{1'b1}}) begin
            cur_r_q   <= '0;
            cur_c_q   <= '0;
            count_q   <= NW'(1);
            running_q <= 1'b1;
            res_kind_q <= bmc_pkg::KIND_START;
            res_cr_q <= '0; res_cc_q <= '0; res_wr_q <= '0; res_wc_q <= '0;
            res_side_q <= bmc_pkg::SIDE_BOTTOM;
            res_dep_q  <= '0;
            state_q    <= S_EMIT;
          end
        end
        S_NB: begin
          // Issue one read a cycle, capture the previous one
          if (k_q != 3'd0) begin
            if (k_q == 3'd5) cur_dist_q <= cm_rdata_q[DW-1:0];
            else cand_q[k_q[1:0] - 2'd1] <= nb_in[k_q[1:0] - 2'd1] && !cm_rdata_q[DW];
          end
          k_q <= k_q + 3'd1;
          if (k_q == 3'd5) state_q <= S_PICK;
        end
        S_PICK: begin
          if (pick.any) begin
            cur_r_q <= new_r;
            cur_c_q <= new_c;
            if (count_q < NW'(bmc_pkg::Cells)) count_q <= count_q + NW'(1);
            res_kind_q <= bmc_pkg::KIND_CARVED;
            res_cr_q <= new_r; res_cc_q <= new_c;
            res_wr_q <= cw_r;  res_wc_q <= cw_c;
            res_side_q <= cw_side;
            res_dep_q  <= new_dist;
            state_q    <= S_EMIT;
          end else begin
            count_q <= count_dec;
            if (count_dec == '0) begin
              sc_first_q <= 1'b1;
              sc_ph_q    <= 1'b0;
              sc_k_q     <= 1'b0;
              sc_i_q     <= '0;
              tag_v_q    <= 1'b0;
              best_q     <= '0;
              best_r_q   <= '0;
              best_c_q   <= '0;
              state_q    <= S_EXIT;
            end else begin
              state_q <= S_POP1;
            end
          end
        end
        S_POP1: state_q <= S_POP2;
        S_POP2: begin
          cur_r_q <= sk_rdata_q[IW-1:CW];
          cur_c_q <= sk_rdata_q[CW-1:0];
          state_q <= S_POP3;
        end
        S_POP3: begin
          res_kind_q <= bmc_pkg::KIND_BACKTRACK;
          res_cr_q <= cur_r_q; res_cc_q <= cur_c_q;
          res_wr_q <= '0; res_wc_q <= '0;
          res_side_q <= bmc_pkg::SIDE_NONE;
          res_dep_q  <= cm_rdata_q[DW-1:0];
          state_q    <= S_EMIT;
        end
        S_EXIT: begin
          // Compare the previous read, keep strictly greater only
          if (tag_v_q && (cm_rdata_q[DW-1:0] > best_q)) begin
            best_q <= cm_rdata_q[DW-1:0]; best_r_q <= tag_r_q; best_c_q <= tag_c_q;
          end
          tag_v_q <= 1'b1;
          tag_r_q <= sc_r;
          tag_c_q <= sc_c;
          if (sc_first_q) begin
            sc_first_q <= 1'b0;
          end else if (!sc_k_q) begin
            sc_k_q <= 1'b1;
          end else begin
            sc_k_q <= 1'b0;
            if (sc_i_q == sc_lim) begin
              sc_i_q  <= '0;
              sc_ph_q <= 1'b1;
            end else begin
              sc_i_q <= sc_i_q + CW'(1);
            end
          end
          if (sc_last) state_q <= S_EXLAST;
        end
        S_EXLAST: begin
          if (cm_rdata_q[DW-1:0] > best_q) begin
            best_q <= cm_rdata_q[DW-1:0]; best_r_q <= tag_r_q; best_c_q <= tag_c_q;
          end
          tag_v_q <= 1'b0;
          state_q <= S_EXRES;
        end
        S_EXRES: begin
          running_q  <= 1'b0;
          res_kind_q <= bmc_pkg::KIND_FINISHED;
          res_cr_q <= best_r_q; res_cc_q <= best_c_q;
          res_dep_q <= best_q;
          if (best_r_q == '0) begin
            res_side_q <= bmc_pkg::SIDE_BOTTOM;
            res_wr_q <= best_r_q; res_wc_q <= best_c_q;
          end else if (best_c_q == '0) begin
            res_side_q <= bmc_pkg::SIDE_LEFT;
            res_wr_q <= best_r_q; res_wc_q <= best_c_q;
          end else begin
            res_side_q <= bmc_pkg::SIDE_NONE;
            res_wr_q <= '0; res_wc_q <= '0;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          // Hand the result over once the output register is free
          if (emit_fire) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output payload, loaded with the valid flag
  logic [bmc_pkg::KindW-1:0] o_kind_q;
  logic [CW-1:0] o_cr_q, o_cc_q, o_wr_q, o_wc_q;
  logic [bmc_pkg::SideW-1:0] o_side_q;
  logic [DW-1:0] o_dep_q;

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      o_kind_q <= res_kind_q;
      o_cr_q   <= res_cr_q;
      o_cc_q   <= res_cc_q;
      o_wr_q   <= res_wr_q;
      o_wc_q   <= res_wc_q;
      o_side_q <= res_side_q;
      o_dep_q  <= res_dep_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = o_kind_q;
  assign out_o.cell_row  = o_cr_q;
  assign out_o.cell_col  = o_cc_q;
  assign out_o.wall_row  = o_wr_q;
  assign out_o.wall_col  = o_wc_q;
  assign out_o.wall_side = o_side_q;
  assign out_o.depth     = o_dep_q;

endmodule
